@@ sv/sv39_page_table_walker_macros.svh @@
// Assertion macros used by the page table walker checker.
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SV39PTW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SV39PTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sv39ptw_pkg.sv @@
// Shared types and constants of the Sv39 page table walker.
`default_nettype none

package sv39ptw_pkg;

  localparam int TABLE_PAGES      = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int SLOT_W           = 9;
  localparam int PAGE_W           = $clog2(TABLE_PAGES);
  localparam int MEM_WORDS        = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int ADDR_W           = PAGE_W + SLOT_W;

  localparam int WORD_W      = 64;
  localparam int INDEX_W     = 12;
  localparam int VA_W        = 39;
  localparam int PA_W        = 56;
  localparam int OFFSET_W    = 12;
  localparam int PTE_PPN_LSB = 10;
  localparam int PPN_W       = 44;
  localparam int PTE_V_BIT   = 0;
  localparam int PTE_U_BIT   = 4;

  localparam int ROOT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [0:0] {
    OP_WRITE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_LIMIT        = 3'd1,
    STAT_MID_INVALID  = 3'd2,
    STAT_LEAF_INVALID = 3'd3,
    STAT_NOT_USER     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_PAGE    = 2'd0,
    CFG_REQUIRE_USER = 2'd1,
    CFG_ADD_OFFSET   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LVL2,
    ST_LVL1,
    ST_LVL0
  } walk_state_t;

endpackage

`default_nettype wire

@@ sv/sv39ptw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sv39ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/sv39_page_table_walker.sv @@
// Sv39 page table walker over a local table memory (4096 x 64 bits).
// A translate reads the level 2, 1 and 0 entries in turn over the single read port, the
// latter two addressed by the entry before, and strobes its result for one cycle; an invalid
// level 2 or 1 entry ends the walk early. A beyond-limit address is reported in the very
// next cycle with no table access. Busy holds off new words during a walk; a write word
// leaves the block idle. After reset a clearing pass zeroes all 4096 words, busy held high.
`default_nettype none

module sv39_page_table_walker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Command channel.
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_operation,
  input  wire logic [sv39ptw_pkg::INDEX_W-1:0]      in_word_index,
  input  wire logic [sv39ptw_pkg::WORD_W-1:0]       in_word_data,
  input  wire logic [sv39ptw_pkg::VA_W-1:0]         in_virtual_address,
  // Result channel, one-cycle strobe, cannot be stalled.
  output logic                                      out_valid,
  output logic      [sv39ptw_pkg::PA_W-1:0]         out_physical_address,
  output logic      [2:0]                           out_status,
  // Configuration write channel.
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sv39ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sv39ptw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Walk control state.
  sv39ptw_pkg::walk_state_t                state_r, state_nxt;
  logic [sv39ptw_pkg::ADDR_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  // Virtual address bits 37..0 of the walk in flight; bit 38 is resolved at accept.
  logic [sv39ptw_pkg::VA_W-2:0]            va_r, va_nxt;

  // Result register: parts the walk from the receiver.
  logic                                    out_valid_r, out_valid_nxt;
  logic [sv39ptw_pkg::PA_W-1:0]            out_pa_r, out_pa_nxt;
  sv39ptw_pkg::status_t                    out_status_r, out_status_nxt;

  // Configuration registers.
  logic [sv39ptw_pkg::ROOT_W-1:0]          root_page_r;
  logic                                    require_user_r;
  logic                                    add_offset_r;

  // Table memory port.
  logic                                    ram_we;
  logic [sv39ptw_pkg::ADDR_W-1:0]          ram_waddr;
  logic [sv39ptw_pkg::WORD_W-1:0]          ram_wdata;
  logic                                    ram_re;
  logic [sv39ptw_pkg::ADDR_W-1:0]          ram_raddr;
  logic [sv39ptw_pkg::WORD_W-1:0]          ram_rdata;

  // Table page named by the entry that just came back from memory. The page count is
  // a power of two, so the modulo is a truncation of the page number.
  logic [sv39ptw_pkg::PAGE_W-1:0]          next_page;
  logic [sv39ptw_pkg::PAGE_W-1:0]          root_page;
  logic [sv39ptw_pkg::PPN_W-1:0]           entry_ppn;
  logic                                    entry_valid;

  assign entry_ppn   = ram_rdata[sv39ptw_pkg::PTE_PPN_LSB +: sv39ptw_pkg::PPN_W];
  assign entry_valid = ram_rdata[sv39ptw_pkg::PTE_V_BIT];
  assign next_page   = sv39ptw_pkg::PAGE_W'(entry_ppn);
  assign root_page   = sv39ptw_pkg::PAGE_W'(root_page_r);

  sv39ptw_ram #(
    .WIDTH (sv39ptw_pkg::WORD_W),
    .DEPTH (sv39ptw_pkg::MEM_WORDS)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A write and a read are never started in the same cycle, so a table write always
  // lands before any read that follows it; no forwarding is needed.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    va_nxt         = va_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_cnt_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = {root_page, in_virtual_address[38:30]};
    out_valid_nxt  = 1'b0;
    out_pa_nxt     = '0;
    out_status_nxt = sv39ptw_pkg::STAT_OK;

    unique case (state_r)
      sv39ptw_pkg::ST_CLEAR: begin
        // Zero one word per cycle after reset.
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + sv39ptw_pkg::ADDR_W'(1);
        if (clr_cnt_r == sv39ptw_pkg::ADDR_W'(sv39ptw_pkg::MEM_WORDS - 1)) begin
          state_nxt = sv39ptw_pkg::ST_IDLE;
        end
      end
      sv39ptw_pkg::ST_IDLE: begin
        if (start) begin
          if (in_operation == sv39ptw_pkg::OP_WRITE) begin
            // Words past the end of the table are dropped.
            ram_we    = (32'(in_word_index) < sv39ptw_pkg::MEM_WORDS);
            ram_waddr = sv39ptw_pkg::ADDR_W'(in_word_index);
            ram_wdata = in_word_data;
          end else if (in_virtual_address[sv39ptw_pkg::VA_W-1]) begin
            // Address at or above 2^38: report at once, no table access.
            out_valid_nxt  = 1'b1;
            out_status_nxt = sv39ptw_pkg::STAT_LIMIT;
          end else begin
            ram_re    = 1'b1;
            va_nxt    = in_virtual_address[sv39ptw_pkg::VA_W-2:0];
            state_nxt = sv39ptw_pkg::ST_LVL2;
          end
        end
      end
      sv39ptw_pkg::ST_LVL2: begin
        if (!entry_valid) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sv39ptw_pkg::STAT_MID_INVALID;
          state_nxt      = sv39ptw_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {next_page, va_r[29:21]};
          state_nxt = sv39ptw_pkg::ST_LVL1;
        end
      end
      sv39ptw_pkg::ST_LVL1: begin
        if (!entry_valid) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sv39ptw_pkg::STAT_MID_INVALID;
          state_nxt      = sv39ptw_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {next_page, va_r[20:12]};
          state_nxt = sv39ptw_pkg::ST_LVL0;
        end
      end
      sv39ptw_pkg::ST_LVL0: begin
        // Leaf entry: check valid, then user permission, then form the address.
        out_valid_nxt = 1'b1;
        state_nxt     = sv39ptw_pkg::ST_IDLE;
        if (!entry_valid) begin
          out_status_nxt = sv39ptw_pkg::STAT_LEAF_INVALID;
        end else if (require_user_r && !ram_rdata[sv39ptw_pkg::PTE_U_BIT]) begin
          out_status_nxt = sv39ptw_pkg::STAT_NOT_USER;
        end else begin
          out_pa_nxt = {entry_ppn, sv39ptw_pkg::OFFSET_W'(0)};
          if (add_offset_r) begin
            out_pa_nxt[sv39ptw_pkg::OFFSET_W-1:0] = va_r[sv39ptw_pkg::OFFSET_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = sv39ptw_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sv39ptw_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    va_r         <= va_nxt;
    out_pa_r     <= out_pa_nxt;
    out_status_r <= out_status_nxt;
  end

  // Configuration writes are always taken; the host must keep them to an idle block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_page_r    <= '0;
      require_user_r <= 1'b1;
      add_offset_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sv39ptw_pkg::CFG_ROOT_PAGE:    root_page_r    <= cfg_data;
        sv39ptw_pkg::CFG_REQUIRE_USER: require_user_r <= cfg_data[0];
        sv39ptw_pkg::CFG_ADD_OFFSET:   add_offset_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready            = 1'b1;
  assign busy                 = (state_r != sv39ptw_pkg::ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_status           = out_status_r;

endmodule

`default_nettype wire

@@ sv/sv39ptw_checker.sv @@
// Port-level checker for the page table walker and its bind.
`default_nettype none

`include "sv39_page_table_walker_macros.svh"

module sv39ptw_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 in_operation,
  input wire logic [sv39ptw_pkg::VA_W-1:0]         in_virtual_address,
  input wire logic                                 out_valid,
  input wire logic [sv39ptw_pkg::PA_W-1:0]         out_physical_address,
  input wire logic [2:0]                           out_status
);

  logic acc_write;
  logic acc_xlate;

  assign acc_write = start && !busy && (in_operation == sv39ptw_pkg::OP_WRITE);
  assign acc_xlate = start && !busy && (in_operation == sv39ptw_pkg::OP_TRANSLATE);

  // A failed translation never leaks an address.
  `SV39PTW_ASSERT_SAME(a_fail_zero_pa, out_valid && (out_status != sv39ptw_pkg::STAT_OK), out_physical_address == '0, "failed translation with nonzero address")

  // An address at or above the limit is answered in the next cycle.
  `SV39PTW_ASSERT_NEXT(a_limit_next, acc_xlate && in_virtual_address[sv39ptw_pkg::VA_W-1], out_valid && (out_status == sv39ptw_pkg::STAT_LIMIT), "limit result missing")

  // A table write yields no result.
  `SV39PTW_ASSERT_NEXT(a_write_silent, acc_write, !out_valid && !busy, "write produced a result or stalled")

  // An in-range translation starts a walk and holds off further words.
  `SV39PTW_ASSERT_NEXT(a_walk_busy, acc_xlate && !in_virtual_address[sv39ptw_pkg::VA_W-1], busy && !out_valid, "walk did not start")

endmodule

bind sv39_page_table_walker sv39ptw_checker u_sv39ptw_checker (.*);

`default_nettype wire

@@ tb/sv39_page_table_walker_tb.sv @@
// Self-checking testbench for the Sv39 page table walker: directed table, then random walks.
module sv39_page_table_walker_tb;
  import sv39ptw_pkg::*;

  // A walk result as it leaves the block: the physical address and why the walk ended.
  typedef struct packed {
    logic [PA_W-1:0] pa;
    status_t         st;
  } walk_result_t;

  // One row of the directed table. A row either sends a command word or writes a
  // register. Rows with a typed result carry the value expected on the result port;
  // the others are checked against the walk predictor.
  typedef struct {
    bit                    is_cfg;
    op_t                   op;
    logic [INDEX_W-1:0]    idx;
    logic [WORD_W-1:0]     data;
    logic [VA_W-1:0]       va;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    walk_result_t          want;
  } dir_row_t;

  // Register index that decodes to nothing; a write there must leave all settings alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int RANDOM_ITEMS  = 1600;
  localparam int PHASES        = 6;
  // Once no result is pending, no walk is in flight and any write word is gone, so
  // these quiet cycles leave the block idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_CYCLES    = 400000;
  localparam int POOL_DEPTH    = 64;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  start              = 1'b0;
  logic                  busy;
  op_t                   in_operation       = OP_WRITE;
  logic [INDEX_W-1:0]    in_word_index      = '0;
  logic [WORD_W-1:0]     in_word_data       = '0;
  logic [VA_W-1:0]       in_virtual_address = '0;
  logic                  out_valid;
  logic [PA_W-1:0]       out_physical_address;
  logic [2:0]            out_status;
  logic                  cfg_valid          = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index          = '0;
  logic [CFG_DATA_W-1:0] cfg_data           = '0;

  // Predictor state: a private copy of the table memory and of the three registers,
  // kept in step with every word and register write the block accepts.
  logic [WORD_W-1:0] table_copy [MEM_WORDS];
  logic [ROOT_W-1:0] walk_root       = '0;
  logic              walk_need_user  = 1'b1;
  logic              walk_add_offset = 1'b0;

  walk_result_t      pending_walks [$];
  logic [VA_W-1:0]   mapped_vas    [$];
  int                errors        = 0;
  int                cycle_count   = 0;
  int                items_sent    = 0;
  int                gap_pct       = 0;

  sv39_page_table_walker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_word_index       (in_word_index),
    .in_word_data        (in_word_data),
    .in_virtual_address  (in_virtual_address),
    .out_valid           (out_valid),
    .out_physical_address(out_physical_address),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hang anywhere, including a result that never comes, ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Walks the private table copy the way the block walks its memory. Levels 2 and 1
  // only test the valid bit, so an entry with R/W/X set up there is walked through.
  // The next table page is the entry's page number modulo the number of table pages,
  // and entry bits above the page number never reach the address.
  function automatic walk_result_t walk_predict(input logic [VA_W-1:0] va);
    walk_result_t      r;
    logic [WORD_W-1:0] pte;
    int unsigned       page;
    r.pa = '0;
    // Everything at or above 2^38 is out of range and reads nothing.
    if (va[VA_W-1]) begin
      r.st = STAT_LIMIT;
      return r;
    end
    page = walk_root % TABLE_PAGES;
    for (int lvl = 2; lvl > 0; lvl--) begin
      pte = table_copy[page * ENTRIES_PER_PAGE + va[OFFSET_W + SLOT_W * lvl +: SLOT_W]];
      if (!pte[PTE_V_BIT]) begin
        r.st = STAT_MID_INVALID;
        return r;
      end
      page = pte[PTE_PPN_LSB +: PPN_W] % TABLE_PAGES;
    end
    pte = table_copy[page * ENTRIES_PER_PAGE + va[OFFSET_W +: SLOT_W]];
    if (!pte[PTE_V_BIT]) begin
      r.st = STAT_LEAF_INVALID;
      return r;
    end
    if (walk_need_user && !pte[PTE_U_BIT]) begin
      r.st = STAT_NOT_USER;
      return r;
    end
    r.pa = {pte[PTE_PPN_LSB +: PPN_W], {OFFSET_W{1'b0}}};
    if (walk_add_offset) r.pa[OFFSET_W-1:0] = va[OFFSET_W-1:0];
    r.st = STAT_OK;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Builds an entry word with random content that leads to the given table page.
  function automatic logic [WORD_W-1:0] pte_to(input int page, input bit v, input bit u);
    logic [WORD_W-1:0] w;
    logic [PPN_W-1:0]  ppn;
    w = rand64();
    ppn = w[PTE_PPN_LSB +: PPN_W];
    ppn = ppn - (ppn % TABLE_PAGES) + PPN_W'(page);
    w[PTE_PPN_LSB +: PPN_W] = ppn;
    w[PTE_V_BIT] = v;
    w[PTE_U_BIT] = u;
    return w;
  endfunction

  // An empty row: every field cleared, enum fields set by name.
  function automatic dir_row_t row_blank();
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.op      = OP_WRITE;
    r.idx     = '0;
    r.data    = '0;
    r.va      = '0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed   = 1'b0;
    r.want.pa = '0;
    r.want.st = STAT_OK;
    return r;
  endfunction

  function automatic dir_row_t row_write(input logic [INDEX_W-1:0] idx,
                                         input logic [WORD_W-1:0] data);
    dir_row_t r;
    r = row_blank();
    r.op   = OP_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t row_walk(input logic [VA_W-1:0] va, input bit typed,
                                        input logic [PA_W-1:0] pa, input status_t st);
    dir_row_t r;
    r = row_blank();
    r.op      = OP_TRANSLATE;
    r.va      = va;
    r.typed   = typed;
    r.want.pa = pa;
    r.want.st = st;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] reg_idx,
                                       input logic [CFG_DATA_W-1:0] reg_val);
    dir_row_t r;
    r = row_blank();
    r.is_cfg  = 1'b1;
    r.reg_idx = reg_idx;
    r.reg_val = reg_val;
    return r;
  endfunction

  // Presents one command word and holds it until the block takes it. Busy is sampled on
  // the falling edge ahead of the rising edge that decides acceptance, so
  // the check never races the block's own updates. Start is left high on return: the
  // caller either presents the next word in the same step or lowers it.
  task automatic send_word(input op_t op, input logic [INDEX_W-1:0] idx,
                           input logic [WORD_W-1:0] data, input logic [VA_W-1:0] va,
                           input bit typed, input walk_result_t want);
    bit hit;
    start              <= 1'b1;
    in_operation       <= op;
    in_word_index      <= idx;
    in_word_data       <= data;
    in_virtual_address <= va;
    do begin
      @(negedge clk);
      hit = (busy === 1'b0);
      @(posedge clk);
    end while (!hit);
    if (op == OP_WRITE) begin
      if (idx < MEM_WORDS) table_copy[idx] = data;
    end else begin
      pending_walks.push_back(typed ? want : walk_predict(va));
    end
  endtask

  // Random part: an optional idle burst ahead of the word, then the word itself.
  task automatic issue(input op_t op, input logic [INDEX_W-1:0] idx,
                       input logic [WORD_W-1:0] data, input logic [VA_W-1:0] va);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    send_word(op, idx, data, va, 1'b0, '0);
    items_sent++;
  endtask

  // Stops sending and waits until every walk has reported and the block has gone quiet.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Valid stays high on return so that back-to-back writes keep a
  // single assignment per step; whoever ends the run of writes lowers it.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit hit;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      hit = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!hit);
    case (idx)
      CFG_ROOT_PAGE:    walk_root       = val[ROOT_W-1:0];
      CFG_REQUIRE_USER: walk_need_user  = val[0];
      CFG_ADD_OFFSET:   walk_add_offset = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] root,
                            input logic [CFG_DATA_W-1:0] need_user,
                            input logic [CFG_DATA_W-1:0] offset);
    cfg_write(CFG_ROOT_PAGE, root);
    cfg_write(CFG_REQUIRE_USER, need_user);
    cfg_write(CFG_ADD_OFFSET, offset);
    cfg_valid <= 1'b0;
  endtask

  // Maps a fresh address through three levels from the current root, then walks it one
  // to three times with different page offsets. Intermediate entries are valid most of
  // the time and leaves carry the user bit most of the time, so deep walks dominate while
  // invalid entries and missing user bits still show up.
  task automatic map_and_walk();
    logic [VA_W-1:0] va;
    int              mid_page;
    int              leaf_page;
    va = VA_W'(rand64());
    va[VA_W-1] = 1'b0;
    mid_page  = $urandom_range(0, TABLE_PAGES - 1);
    leaf_page = $urandom_range(0, TABLE_PAGES - 1);
    issue(OP_WRITE,
          INDEX_W'((walk_root % TABLE_PAGES) * ENTRIES_PER_PAGE + va[30 +: SLOT_W]),
          pte_to(mid_page, $urandom_range(9) != 0, $urandom_range(1) != 0),
          VA_W'(rand64()));
    issue(OP_WRITE, INDEX_W'(mid_page * ENTRIES_PER_PAGE + va[21 +: SLOT_W]),
          pte_to(leaf_page, $urandom_range(9) != 0, $urandom_range(1) != 0),
          VA_W'(rand64()));
    issue(OP_WRITE, INDEX_W'(leaf_page * ENTRIES_PER_PAGE + va[OFFSET_W +: SLOT_W]),
          pte_to($urandom_range(0, TABLE_PAGES - 1), $urandom_range(9) != 0,
                 $urandom_range(3) != 0), VA_W'(rand64()));
    repeat ($urandom_range(1, 3)) begin
      va[OFFSET_W-1:0] = OFFSET_W'($urandom);
      issue(OP_TRANSLATE, INDEX_W'($urandom), rand64(), va);
    end
    if (mapped_vas.size() < POOL_DEPTH) mapped_vas.push_back(va);
    else mapped_vas[$urandom_range(0, POOL_DEPTH - 1)] = va;
  endtask

  // Results are sampled mid-cycle: the strobe is high for exactly one cycle, so the
  // falling edge inside it sees the same values the closing rising edge accepts.
  always @(negedge clk) begin
    walk_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_walks.size() == 0) begin
        $display("%0t: unexpected result: pa %h status %0d", $time,
                 out_physical_address, out_status);
        errors++;
      end else begin
        want = pending_walks.pop_front();
        if (out_physical_address !== want.pa) begin
          $display("%0t: physical_address expected %h actual %h", $time, want.pa,
                   out_physical_address);
          errors++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t        dir_rows [$];
    logic [VA_W-1:0] va;
    int              pick;

    foreach (table_copy[i]) table_copy[i] = '0;

    // Directed table, starting from the reset settings: root page 0, user bit required,
    // no offset. It climbs one level at a time from an empty memory to a full walk.
    // Empty memory: a missing top-level entry, and both edges of the address limit.
    dir_rows.push_back(row_walk(39'h0, 1'b1, '0, STAT_MID_INVALID));
    dir_rows.push_back(row_walk(39'h40_0000_0000, 1'b1, '0, STAT_LIMIT));
    dir_rows.push_back(row_walk(39'h7F_FFFF_FFFF, 1'b1, '0, STAT_LIMIT));
    dir_rows.push_back(row_walk(39'h3F_FFFF_FFFF, 1'b1, '0, STAT_MID_INVALID));
    // Level 2 points at page 1, whose level-1 entry is still empty.
    dir_rows.push_back(row_write(12'd0, 64'h401));
    dir_rows.push_back(row_walk(39'h0, 1'b1, '0, STAT_MID_INVALID));
    // Level 1 points at page 2, whose leaf is still empty.
    dir_rows.push_back(row_write(12'd512, 64'h801));
    dir_rows.push_back(row_walk(39'h0, 1'b1, '0, STAT_LEAF_INVALID));
    // A valid leaf without the user bit is refused while the user bit is required.
    dir_rows.push_back(row_write(12'd1024, 64'h48C01));
    dir_rows.push_back(row_walk(39'h0, 1'b1, '0, STAT_NOT_USER));
    // An all-ones leaf: the largest page number, high bits dropped from the address.
    dir_rows.push_back(row_write(12'd1024, '1));
    dir_rows.push_back(row_walk(39'h0, 1'b1, 56'hFF_FFFF_FFFF_F000, STAT_OK));
    // A top-level entry that looks like a leaf (R/W/X and high bits set) is walked
    // through all the same; with offsets off the low address bits do not show.
    dir_rows.push_back(row_write(12'd0, 64'hFFC0_0000_0000_040F));
    dir_rows.push_back(row_walk(39'h123, 1'b1, 56'hFF_FFFF_FFFF_F000, STAT_OK));
    // Only the low bits of a huge level-1 page number pick the next table page.
    dir_rows.push_back(row_write(12'd512, 64'h003F_FFFF_FFFE_8801));
    dir_rows.push_back(row_walk(39'h0, 1'b0, '0, STAT_OK));
    // Drop the user requirement (only bit 0 of the data counts) and add offsets.
    dir_rows.push_back(row_cfg(CFG_REQUIRE_USER, 3'b110));
    dir_rows.push_back(row_cfg(CFG_ADD_OFFSET, 3'b001));
    dir_rows.push_back(row_write(12'd1024, 64'h1401));
    dir_rows.push_back(row_walk(39'hABC, 1'b1, 56'h5ABC, STAT_OK));
    // A failed walk reports a zero address even with offsets on.
    dir_rows.push_back(row_walk(39'h40_0000_0ABC, 1'b1, '0, STAT_LIMIT));
    // Highest root page and the last word of memory.
    dir_rows.push_back(row_cfg(CFG_ROOT_PAGE, 3'd7));
    dir_rows.push_back(row_write(12'd4095, '1));
    dir_rows.push_back(row_walk(39'h3F_FFFF_FFFF, 1'b1, '0, STAT_MID_INVALID));
    // A write to the unused register index changes nothing.
    dir_rows.push_back(row_cfg(CFG_SPARE, 3'd7));
    dir_rows.push_back(row_walk(39'hFFF, 1'b1, '0, STAT_MID_INVALID));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Reset is released ahead of the first word so the block is in its clearing pass before
    // busy is looked at; the first word then waits out the clearing on the handshake.
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        // Registers change only with the block idle.
        if (i > 0 && !dir_rows[i-1].is_cfg) drain_results();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        if (i + 1 == dir_rows.size() || !dir_rows[i+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].data, dir_rows[i].va,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part in phases, each with its own register settings. The first two phases
    // take the extremes; the rest are random, with spare data bits set at random too.
    // Idle bursts come and go between phases, and phase 3 and the last phase have none at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       set_config(3'd7, 3'd1, 3'd1);
        1:       set_config(3'd0, 3'd0, 3'd0);
        default: set_config(3'($urandom), 3'($urandom), 3'($urandom));
      endcase
      gap_pct = (ph == PHASES - 1 || ph == 3) ? 0 : 20 + 15 * (ph % 2);
      while (items_sent < (ph + 1) * RANDOM_ITEMS / PHASES) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          map_and_walk();
        end else if (pick < 68 && mapped_vas.size() != 0) begin
          // Revisit a mapped address; sometimes keep only the level 2 and level 1 slots so that
          // the leaf lookup lands on entries written for other addresses.
          va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
          va[OFFSET_W-1:0] = OFFSET_W'($urandom);
          if ($urandom_range(4) == 0) va[20:0] = 21'($urandom);
          issue(OP_TRANSLATE, INDEX_W'($urandom), rand64(), va);
        end else if (pick < 82) begin
          // Fully random address: half of these are beyond the limit.
          issue(OP_TRANSLATE, INDEX_W'($urandom), rand64(), VA_W'(rand64()));
        end else begin
          issue(OP_WRITE, INDEX_W'($urandom), rand64(), VA_W'(rand64()));
        end
        // Now and then the sender holds off until every walk has reported.
        if ($urandom_range(79) == 0) drain_results();
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sv39ptw_pkg.sv
sv/sv39ptw_ram.sv
sv/sv39_page_table_walker.sv
sv/sv39ptw_checker.sv
tb/sv39_page_table_walker_tb.sv
